// File: design/zsu_pkg.sv
// Shared types and constants for the zero-stuffing upsampler with third-order feedback filter.
// Used by every module of the block; no dependencies.
package zsu_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int COEF_BITS   = 18;
   localparam int FACT_BITS   = 7;
   localparam int MAX_FACTOR  = 64;
   localparam int CNT_BITS    = $clog2(MAX_FACTOR);
   localparam int FRAC_BITS   = COEF_BITS - 2;
   localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
   localparam int SUM_BITS    = PROD_BITS + 2;
   localparam int Q_BITS      = SUM_BITS - FRAC_BITS;
   localparam int IDX_BITS    = 3;

   localparam logic [IDX_BITS-1:0] CSR_FACTOR      = 3'd0;
   localparam logic [IDX_BITS-1:0] CSR_COEF_OLDEST = 3'd1;
   localparam logic [IDX_BITS-1:0] CSR_COEF_MIDDLE = 3'd2;
   localparam logic [IDX_BITS-1:0] CSR_COEF_NEWEST = 3'd3;

   localparam logic signed [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [Q_BITS-1:0]   SAT_MAX    = Q_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [Q_BITS-1:0]   SAT_MIN    = Q_BITS'(-(1 << (SAMPLE_BITS - 1)));

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [CNT_BITS-1:0]           run_m1;   // outputs in the run, minus one
   } cmd_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last;
   } result_type;

   typedef struct packed {
      logic signed [COEF_BITS-1:0] oldest;
      logic signed [COEF_BITS-1:0] middle;
      logic signed [COEF_BITS-1:0] newest;
   } coef_type;

   // zero acts as one, anything above the maximum acts as the maximum
   function automatic logic [CNT_BITS-1:0] run_len_m1(input logic [FACT_BITS-1:0] factor);
      logic [CNT_BITS-1:0] r;
      if (factor == '0) begin
         r = '0;
      end else if (factor > FACT_BITS'(MAX_FACTOR)) begin
         r = CNT_BITS'(MAX_FACTOR - 1);
      end else begin
         r = CNT_BITS'(factor - FACT_BITS'(1));
      end
      return r;
   endfunction

endpackage

// File: design/zsu_front.sv
// Front end: accepts requests, works out the run length and queues commands (two entries).
// Depends on zsu_pkg.
module zsu_front
   import zsu_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   input  logic signed [SAMPLE_BITS-1:0] req_in_sample,
   output logic                          req_full,
   input  logic [FACT_BITS-1:0]          factor,
   input  logic                          cmd_pop,
   output logic                          cmd_empty,
   output cmd_type                       cmd
);

   cmd_type     mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   logic        pop;

   assign req_full  = (count_ff == 2'd2);
   assign cmd_empty = (count_ff == 2'd0);
   assign cmd       = mem_ff[rd_ptr_ff];
   assign push      = req_push && !req_full;
   assign pop       = cmd_pop && !cmd_empty;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= '{sample: req_in_sample, run_m1: run_len_m1(factor)};
      end
   end

endmodule

// File: design/zsu_back.sv
// Back end: runs the feedback filter over each run, multiply state then accumulate state.
// Depends on zsu_pkg; takes commands from zsu_front, hands results to zsu_out_buf.
module zsu_back
   import zsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  coef_type   coef,
   input  logic       cmd_empty,
   input  cmd_type    cmd,
   output logic       cmd_pop,
   input  logic       res_full,
   output logic       res_push,
   output result_type res
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_MUL  = 3'b010,
      ST_ACC  = 3'b100
   } back_state_type;

   back_state_type                 state_ff, state_in;
   logic signed [SAMPLE_BITS-1:0]  sample_ff, sample_in;
   logic [CNT_BITS-1:0]            remain_ff, remain_in;
   logic signed [SAMPLE_BITS-1:0]  hist_ff [3];   // oldest, middle, newest
   logic signed [PROD_BITS-1:0]    prod_ff [3];
   logic signed [SUM_BITS-1:0]     acc;
   logic signed [Q_BITS-1:0]       quot;
   logic signed [SAMPLE_BITS-1:0]  y;

   // stuffed value sits FRAC_BITS up, rounded half up, then saturated
   always_comb begin
      acc = (SUM_BITS'(sample_ff) <<< FRAC_BITS)
          + SUM_BITS'(prod_ff[0]) + SUM_BITS'(prod_ff[1]) + SUM_BITS'(prod_ff[2])
          + ROUND_HALF;
      quot = acc[SUM_BITS-1:FRAC_BITS];
      if (quot > SAT_MAX) begin
         y = SAT_MAX[SAMPLE_BITS-1:0];
      end else if (quot < SAT_MIN) begin
         y = SAT_MIN[SAMPLE_BITS-1:0];
      end else begin
         y = quot[SAMPLE_BITS-1:0];
      end
   end

   assign res = '{sample: y, last: (remain_ff == '0)};

   always_comb begin
      state_in  = state_ff;
      sample_in = sample_ff;
      remain_in = remain_ff;
      cmd_pop   = 1'b0;
      res_push  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop   = 1'b1;
               sample_in = cmd.sample;
               remain_in = cmd.run_m1;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (!res_full) begin
               res_push = 1'b1;
               if (remain_ff == '0) begin
                  if (!cmd_empty) begin
                     cmd_pop   = 1'b1;
                     sample_in = cmd.sample;
                     remain_in = cmd.run_m1;
                     state_in  = ST_MUL;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  sample_in = '0;
                  remain_in = remain_ff - CNT_BITS'(1);
                  state_in  = ST_MUL;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         hist_ff[0] <= '0;
         hist_ff[1] <= '0;
         hist_ff[2] <= '0;
      end else begin
         state_ff <= state_in;
         if (res_push) begin
            hist_ff[0] <= hist_ff[1];
            hist_ff[1] <= hist_ff[2];
            hist_ff[2] <= y;
         end
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      remain_ff <= remain_in;
      if (state_ff == ST_MUL) begin
         prod_ff[0] <= hist_ff[0] * coef.oldest;
         prod_ff[1] <= hist_ff[1] * coef.middle;
         prod_ff[2] <= hist_ff[2] * coef.newest;
      end
   end

endmodule

// File: design/zsu_out_buf.sv
// Two-entry result queue that decouples the filter from the response side.
// Depends on zsu_pkg.
module zsu_out_buf
   import zsu_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          res_push,
   input  result_type                    res,
   output logic                          res_full,
   input  logic                          rsp_pop,
   output logic                          rsp_empty,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_sample,
   output logic                          rsp_last_of_run
);

   result_type  mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   logic        pop;

   assign res_full        = (count_ff == 2'd2);
   assign rsp_empty       = (count_ff == 2'd0);
   assign rsp_out_sample  = mem_ff[rd_ptr_ff].sample;
   assign rsp_last_of_run = mem_ff[rd_ptr_ff].last;
   assign push            = res_push && !res_full;
   assign pop             = rsp_pop && !rsp_empty;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= res;
      end
   end

endmodule

// File: design/zero_stuff_upsampler_iir3_unit.sv
// Top level: zero-stuffing upsampler with third-order feedback filter, plus control registers.
// Depends on zsu_pkg, zsu_front, zsu_back, zsu_out_buf.
//
//   channel   ports                                   handshake
//   request   req_in_sample                            req_push / req_full
//   response  rsp_out_sample, rsp_last_of_run          rsp_pop / rsp_empty
//   control   csr_index, csr_wdata                     csr_we
//
// Each result passes through a multiply state for the three feedback products, then an
// accumulate state for the sum, rounding and saturation that writes the history the next
// result needs. A request occupies the filter for one such pass per output of its run.
// Two-entry queues sit on both sides, so requests are taken while results wait.
// Synchronous reset clears the history, the queues and the registers (factor to one).
module zero_stuff_upsampler_iir3_unit
   import zsu_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   input  logic signed [SAMPLE_BITS-1:0] req_in_sample,
   output logic                          req_full,
   input  logic                          rsp_pop,
   output logic                          rsp_empty,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_sample,
   output logic                          rsp_last_of_run,
   input  logic                          csr_we,
   input  logic [IDX_BITS-1:0]           csr_index,
   input  logic [COEF_BITS-1:0]          csr_wdata
);

   logic [FACT_BITS-1:0] factor_ff;
   coef_type             coef_ff;
   logic                 cmd_pop;
   logic                 cmd_empty;
   cmd_type              cmd;
   logic                 res_full;
   logic                 res_push;
   result_type           res;

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= FACT_BITS'(1);
         coef_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FACTOR:      factor_ff      <= csr_wdata[FACT_BITS-1:0];
            CSR_COEF_OLDEST: coef_ff.oldest <= csr_wdata;
            CSR_COEF_MIDDLE: coef_ff.middle <= csr_wdata;
            CSR_COEF_NEWEST: coef_ff.newest <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   zsu_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_in_sample (req_in_sample),
      .req_full      (req_full),
      .factor        (factor_ff),
      .cmd_pop       (cmd_pop),
      .cmd_empty     (cmd_empty),
      .cmd           (cmd)
   );

   zsu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .coef      (coef_ff),
      .cmd_empty (cmd_empty),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .res_full  (res_full),
      .res_push  (res_push),
      .res       (res)
   );

   zsu_out_buf u_out_buf (
      .clock           (clock),
      .reset           (reset),
      .res_push        (res_push),
      .res             (res),
      .res_full        (res_full),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_out_sample  (rsp_out_sample),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // the filter never writes a result into a full queue
   assert property (@(posedge clock) disable iff (reset) res_push |-> !res_full)
      else $error("result written into full queue");

   // the filter never takes a command from an empty queue
   assert property (@(posedge clock) disable iff (reset) cmd_pop |-> !cmd_empty)
      else $error("command taken from empty queue");

   // results never come back to back: after a push the filter is in the multiply or idle state
   assert property (@(posedge clock) disable iff (reset) res_push |=> !res_push)
      else $error("results pushed on consecutive cycles");

   // the result queue comes out of reset empty and the request queue not full
   assert property (@(posedge clock) $past(reset) |-> rsp_empty && !req_full)
      else $error("queues not empty after reset");

endmodule

// File: tb/sv/tb_zero_stuff_upsampler_iir3_unit.sv
// Self-checking testbench for zero_stuff_upsampler_iir3_unit: directed and random requests,
// an in-bench model of the stuffing and third-order feedback filter, and a result checker.
// Depends on zsu_pkg and the block's RTL only.
module tb_zero_stuff_upsampler_iir3_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import zsu_pkg::*;

   localparam logic [IDX_BITS-1:0] CSR_SPARE_LO = 3'd4;
   localparam logic [IDX_BITS-1:0] CSR_SPARE_HI = 3'd7;
   localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
   localparam longint COEF_MAX   = (longint'(1) <<< (COEF_BITS - 1)) - 1;
   localparam longint COEF_MIN   = -COEF_MAX - 1;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_push = 1'b0;
   logic signed [SAMPLE_BITS-1:0] req_in_sample = '0;
   logic                          req_full;
   logic                          rsp_pop = 1'b0;
   logic                          rsp_empty;
   logic signed [SAMPLE_BITS-1:0] rsp_out_sample;
   logic                          rsp_last_of_run;
   logic                          csr_we = 1'b0;
   logic [IDX_BITS-1:0]           csr_index = CSR_FACTOR;
   logic [COEF_BITS-1:0]          csr_wdata = '0;

   // bench copy of the control registers and the output history
   logic [FACT_BITS-1:0]          factor_reg = FACT_BITS'(1);
   logic signed [COEF_BITS-1:0]   weight_oldest = '0;
   logic signed [COEF_BITS-1:0]   weight_middle = '0;
   logic signed [COEF_BITS-1:0]   weight_newest = '0;
   longint                        y_hist [3] = '{0, 0, 0};

   logic signed [SAMPLE_BITS-1:0] sample_backlog [$];
   result_type                    awaited_outputs [$];
   int                            mismatches = 0;
   bit                            bursts_on = 1'b1;
   int                            send_gap = 0;
   int                            pop_gap = 0;

   zero_stuff_upsampler_iir3_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_in_sample   (req_in_sample),
      .req_full        (req_full),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_out_sample  (rsp_out_sample),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // one filter output: exact sum, round half up, saturate, shift into history
   function automatic logic signed [SAMPLE_BITS-1:0] iir_output(input longint stuffed);
      longint acc;
      longint y;
      acc = stuffed * (longint'(1) <<< FRAC_BITS)
          + y_hist[0] * longint'(weight_oldest)
          + y_hist[1] * longint'(weight_middle)
          + y_hist[2] * longint'(weight_newest);
      y = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (y > SAMPLE_MAX) y = SAMPLE_MAX;
      if (y < SAMPLE_MIN) y = SAMPLE_MIN;
      y_hist[0] = y_hist[1];
      y_hist[1] = y_hist[2];
      y_hist[2] = y;
      return y[SAMPLE_BITS-1:0];
   endfunction

   task automatic expect_run(input logic signed [SAMPLE_BITS-1:0] x);
      int         n;
      result_type r;
      n = int'(factor_reg);
      if (n < 1) n = 1;
      if (n > MAX_FACTOR) n = MAX_FACTOR;
      for (int k = 0; k < n; k++) begin
         r.sample = iir_output(k == 0 ? longint'(x) : 0);
         r.last   = (k == n - 1);
         awaited_outputs.push_back(r);
      end
   endtask

   task automatic csr_write(input logic [IDX_BITS-1:0] idx, input logic [COEF_BITS-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_FACTOR:      factor_reg    = val[FACT_BITS-1:0];
         CSR_COEF_OLDEST: weight_oldest = val;
         CSR_COEF_MIDDLE: weight_middle = val;
         CSR_COEF_NEWEST: weight_newest = val;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // holds off until every queued request is taken and every result has come back
   task automatic drain();
      do @(negedge clock);
      while (sample_backlog.size() != 0 || req_push || awaited_outputs.size() != 0);
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
      logic signed [SAMPLE_BITS-1:0] s;
      case ($urandom_range(0, 9))
         0:       s = SAMPLE_BITS'(SAMPLE_MIN);
         1:       s = SAMPLE_BITS'(SAMPLE_MAX);
         2:       s = '0;
         3:       s = SAMPLE_BITS'(int'($urandom_range(0, 255)) - 128);
         default: s = SAMPLE_BITS'($urandom);
      endcase
      return s;
   endfunction

   function automatic logic [COEF_BITS-1:0] rand_coef();
      logic [COEF_BITS-1:0] c;
      case ($urandom_range(0, 4))
         0:       c = COEF_BITS'($urandom);
         1:       c = COEF_BITS'(int'($urandom_range(0, 32767)) - 16384);
         2:       c = $urandom_range(0, 1) ? COEF_BITS'(COEF_MAX) : COEF_BITS'(COEF_MIN);
         3:       c = '0;
         default: c = COEF_BITS'(int'($urandom_range(0, 131071)) - 65536);
      endcase
      return c;
   endfunction

   // request side
   always @(posedge clock) begin : drive_req
      logic                          nxt_push;
      logic signed [SAMPLE_BITS-1:0] nxt_sample;
      nxt_push   = req_push;
      nxt_sample = req_in_sample;
      if (reset) begin
         nxt_push = 1'b0;
      end else begin
         if (req_push && !req_full) begin
            expect_run(req_in_sample);
            nxt_push = 1'b0;
         end
         if (!nxt_push) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (sample_backlog.size() != 0) begin
               if (bursts_on && $urandom_range(0, 5) == 0) begin
                  send_gap = $urandom_range(1, 7) - 1;
               end else begin
                  nxt_push   = 1'b1;
                  nxt_sample = sample_backlog.pop_front();
               end
            end
         end
      end
      req_push      <= nxt_push;
      req_in_sample <= nxt_sample;
   end

   // result side
   always @(posedge clock) begin : watch_rsp
      result_type want;
      logic       nxt_pop;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (awaited_outputs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result with nothing outstanding: sample %0d last %0b",
                        rsp_out_sample, rsp_last_of_run);
         end else begin
            want = awaited_outputs.pop_front();
            if (want.sample !== rsp_out_sample || want.last !== rsp_last_of_run) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: sample exp %0d got %0d, last exp %0b got %0b",
                           want.sample, rsp_out_sample, want.last, rsp_last_of_run);
            end
         end
      end
      nxt_pop = 1'b1;
      if (reset) begin
         nxt_pop = 1'b0;
      end else if (pop_gap > 0) begin
         pop_gap--;
         nxt_pop = 1'b0;
      end else if (bursts_on && $urandom_range(0, 4) == 0) begin
         pop_gap = $urandom_range(1, 7) - 1;
         nxt_pop = 1'b0;
      end
      rsp_pop <= nxt_pop;
   end

   initial begin : sequencer
      int n_items;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset settings: factor one, no feedback, so each output is the request sample
      @(negedge clock);
      sample_backlog = '{'0, 16'sh7fff, 16'sh8000, -16'sd1, 16'sd1, 16'sh5555, 16'shaaaa};
      drain();

      // factor field zero with the spare upper bits set; extreme weights saturate
      csr_write(CSR_FACTOR, 18'h3ff80);
      csr_write(CSR_COEF_OLDEST, COEF_BITS'(COEF_MAX));
      csr_write(CSR_COEF_MIDDLE, COEF_BITS'(COEF_MIN));
      csr_write(CSR_COEF_NEWEST, COEF_BITS'(COEF_MAX));
      csr_write(CSR_SPARE_LO, COEF_BITS'($urandom));
      @(negedge clock);
      sample_backlog = '{16'sh7fff, 16'sh8000, '0};
      drain();

      // factor above the maximum; weight of minus one half lands on exact halves
      csr_write(CSR_FACTOR, COEF_BITS'(127));
      csr_write(CSR_COEF_OLDEST, '0);
      csr_write(CSR_COEF_MIDDLE, '0);
      csr_write(CSR_COEF_NEWEST, COEF_BITS'(-32768));
      csr_write(CSR_SPARE_HI, COEF_BITS'($urandom));
      @(negedge clock);
      sample_backlog = '{16'sd3, -16'sd3};
      drain();

      csr_write(CSR_FACTOR, COEF_BITS'(MAX_FACTOR + 1));
      csr_write(CSR_COEF_NEWEST, COEF_BITS'(65536));
      csr_write(CSR_COEF_MIDDLE, COEF_BITS'(-32768));
      @(negedge clock);
      sample_backlog = '{16'sd1000, 16'sd1};
      drain();

      for (int b = 0; b < 8; b++) begin
         if (b == 3) begin
            csr_write(CSR_FACTOR, COEF_BITS'(MAX_FACTOR));
            n_items = 5;
         end else if (b == 5) begin
            csr_write(CSR_FACTOR, '0);
            n_items = 42;
         end else if (b == 6) begin
            csr_write(CSR_FACTOR, COEF_BITS'($urandom_range(MAX_FACTOR + 1, 127)));
            n_items = 5;
         end else begin
            csr_write(CSR_FACTOR, COEF_BITS'($urandom_range(1, 8)));
            n_items = 42;
         end
         csr_write(CSR_COEF_OLDEST, rand_coef());
         csr_write(CSR_COEF_MIDDLE, rand_coef());
         csr_write(CSR_COEF_NEWEST, rand_coef());
         if ($urandom_range(0, 1))
            csr_write(IDX_BITS'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI)),
                      COEF_BITS'($urandom));
         bursts_on = (b != 7);
         @(negedge clock);
         for (int i = 0; i < n_items; i++)
            sample_backlog.push_back(rand_sample());
         drain();
      end

      // catch anything the block emits after the last expected result
      repeat (16) @(negedge clock);
      if (mismatches == 0 && awaited_outputs.size() == 0) begin
         $display("zero_stuff_upsampler_iir3_unit verification clean");
      end else begin
         $display("zero_stuff_upsampler_iir3_unit verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("zero_stuff_upsampler_iir3_unit verification failed");
      $finish;
   end

endmodule
